// File: design/afrf_pkg.sv
// Shared types and constants for the ALU with flags and register file.
package afrf_pkg;

  localparam int DATA_W   = 32;
  localparam int IMM_BITS = 21;
  localparam int OP_W     = 4;
  localparam int IDX_W    = 3;

  // Bit positions in the NZVC status nibble
  localparam int FLAG_N = 3;
  localparam int FLAG_Z = 2;
  localparam int FLAG_V = 1;
  localparam int FLAG_C = 0;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_SHL = 4'd2,
    OP_SHR = 4'd3,
    OP_ROL = 4'd4,
    OP_ROR = 4'd5,
    OP_AND = 4'd6,
    OP_OR  = 4'd7,
    OP_XOR = 4'd8,
    OP_NOT = 4'd9
  } alu_op_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [IDX_W-1:0]    dest_reg;
    logic [IDX_W-1:0]    src_reg;
    logic                use_immediate;
    logic [IMM_BITS-1:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              flag_zero;
    logic              flag_negative;
    logic              flag_overflow;
    logic              flag_carry;
    logic              invalid_op;
  } out_item_t;

  // Execute unit result bundle
  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic [3:0]        flags;
    logic              invalid;
  } alu_res_t;

endpackage

// File: design/afrf_alu.sv
// Execute datapath: adder, barrel shifter/rotator, logic ops and NZVC update.
module afrf_alu (
  input  logic [afrf_pkg::OP_W-1:0]   op_code,
  input  logic [afrf_pkg::DATA_W-1:0] left,
  input  logic [afrf_pkg::DATA_W-1:0] right,
  input  logic [3:0]                  flags_in,
  output afrf_pkg::alu_res_t          res
);
  import afrf_pkg::*;

  alu_op_t           op;
  logic [4:0]        n;
  logic              cnt_one;
  logic [DATA_W-1:0] b_opnd;
  logic [DATA_W-1:0] sum;
  logic [DATA_W:0]   shl_w;
  logic [DATA_W:0]   shr_w;
  logic [2*DATA_W-1:0] rol_w;
  logic [2*DATA_W-1:0] ror_w;
  logic [DATA_W-1:0] r;
  logic [3:0]        f;
  logic              inv;

  assign op      = alu_op_t'(op_code);
  assign n       = right[4:0];
  assign cnt_one = (n == 5'd1);

  // Add/sub share one adder; sub adds the two's complement
  assign b_opnd = (op == OP_SUB) ? (~right + 32'd1) : right;
  assign sum    = left + b_opnd;

  // Shifts keep the last bit out in the extra position
  assign shl_w = {1'b0, left} << n;
  assign shr_w = {left, 1'b0} >> n;
  assign rol_w = {left, left} << n;
  assign ror_w = {left, left} >> n;

  always_comb begin
    r   = '0;
    f   = flags_in;
    inv = 1'b0;
    unique case (op) inside
      OP_ADD, OP_SUB: begin
        r         = sum;
        f[FLAG_Z] = (sum == '0);
        f[FLAG_N] = sum[DATA_W-1];
        f[FLAG_V] = (left[DATA_W-1] == b_opnd[DATA_W-1]) &&
                    (sum[DATA_W-1] != left[DATA_W-1]);
        f[FLAG_C] = (sum < left);
      end
      OP_SHL: begin
        r         = shl_w[DATA_W-1:0];
        f[FLAG_Z] = (r == '0);
        f[FLAG_N] = r[DATA_W-1];
        if (cnt_one) begin
          f[FLAG_V] = r[DATA_W-1] ^ shl_w[DATA_W];
        end
        f[FLAG_C] = shl_w[DATA_W];
      end
      OP_SHR: begin
        r         = shr_w[DATA_W:1];
        f[FLAG_Z] = (r == '0);
        f[FLAG_N] = r[DATA_W-1];
        if (cnt_one) begin
          f[FLAG_V] = left[DATA_W-1];
        end
        f[FLAG_C] = shr_w[0];
      end
      OP_ROL: begin
        r         = rol_w[2*DATA_W-1:DATA_W];
        f[FLAG_Z] = (r == '0);
        f[FLAG_N] = r[DATA_W-1];
        if (cnt_one) begin
          f[FLAG_V] = r[DATA_W-1] ^ r[0];
        end
        f[FLAG_C] = r[0];
      end
      OP_ROR: begin
        r         = ror_w[DATA_W-1:0];
        f[FLAG_Z] = (r == '0);
        f[FLAG_N] = r[DATA_W-1];
        if (cnt_one) begin
          f[FLAG_V] = r[DATA_W-1] ^ r[DATA_W-2];
        end
        f[FLAG_C] = r[DATA_W-1];
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (op == OP_AND) begin
          r = left & right;
        end else if (op == OP_OR) begin
          r = left | right;
        end else begin
          r = left ^ right;
        end
        f[FLAG_Z] = (r == '0);
        f[FLAG_N] = r[DATA_W-1];
        f[FLAG_V] = 1'b0;
        f[FLAG_C] = 1'b0;
      end
      // Complement leaves status untouched
      OP_NOT: begin
        r = ~left;
      end
      default: begin
        inv = 1'b1;
      end
    endcase
  end

  assign res.result  = r;
  assign res.flags   = f;
  assign res.invalid = inv;

endmodule

// File: design/alu_with_flags_and_register_file_unit.sv
// Top level: register file memory, operand forwarding, execute stage and output register.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one decoded instruction
//   per transaction. Output channel (out_valid/out_ready/out_data) returns one
//   result per instruction, in order: the value written back, the NZVC status
//   after the instruction, and invalid_op for unknown operation codes.
//   An accepted instruction passes the execute stage register, then the
//   output register. Throughput: one instruction per cycle unless the
//   receiver stalls. The register file is read synchronously at accept;
//   execute and write-back complete as the instruction leaves the execute
//   stage, and a write on the same edge as a dependent read is forwarded.
//   Reset (rst_n low, synchronous) clears the pipeline, the status and the
//   written marks, so all registers read as zero; no clearing pass is needed.
//   When out_ready is low the result holds in the output register, one more
//   instruction can wait in the execute stage, and then in_ready drops.
module alu_with_flags_and_register_file_unit #(
  parameter int NUM_REGS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  afrf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output afrf_pkg::out_item_t out_data
);
  import afrf_pkg::*;

  localparam int AW = $clog2(NUM_REGS);

  // Register file storage and per-entry written marks
  logic [DATA_W-1:0]   rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] ent_valid_r;

  // Execute stage
  logic                s1_valid_r;
  in_item_t            s1_item_r;
  logic [DATA_W-1:0]   rd_data_r;
  logic [DATA_W-1:0]   rs_data_r;
  logic                rd_ok_r;
  logic                rs_ok_r;
  logic                fwd_rd_r;
  logic                fwd_rs_r;
  logic [DATA_W-1:0]   fwd_data_r;
  logic [3:0]          flags_r;

  // Output register
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_data_r;

  logic                in_fire;
  logic                s1_fire;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       rs_addr;
  logic [DATA_W-1:0]   left_op;
  logic [DATA_W-1:0]   reg_right;
  logic [DATA_W-1:0]   imm_ext;
  logic [DATA_W-1:0]   right_op;
  alu_res_t            alu_res;

  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    return (32'(idx) < NUM_REGS);
  endfunction

  // Handshake
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign rd_addr = in_data.dest_reg[AW-1:0];
  assign rs_addr = in_data.src_reg[AW-1:0];
  assign wr_addr = s1_item_r.dest_reg[AW-1:0];
  assign wr_en   = s1_fire && !alu_res.invalid && idx_in_range(s1_item_r.dest_reg);

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= alu_res.result;
    end
  end

  // Memory read ports, registered at accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= rf_mem[rd_addr];
      rs_data_r <= rf_mem[rs_addr];
    end
  end

  // Written marks: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
    end else if (wr_en) begin
      ent_valid_r[wr_addr] <= 1'b1;
    end
  end

  // Execute stage load, with forwarding of the write on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r  <= in_data;
      rd_ok_r    <= idx_in_range(in_data.dest_reg) && ent_valid_r[rd_addr];
      rs_ok_r    <= idx_in_range(in_data.src_reg) && ent_valid_r[rs_addr];
      fwd_rd_r   <= wr_en && (s1_item_r.dest_reg == in_data.dest_reg);
      fwd_rs_r   <= wr_en && (s1_item_r.dest_reg == in_data.src_reg);
      fwd_data_r <= alu_res.result;
    end
  end

  // Operand select
  assign left_op   = fwd_rd_r ? fwd_data_r : (rd_ok_r ? rd_data_r : '0);
  assign reg_right = fwd_rs_r ? fwd_data_r : (rs_ok_r ? rs_data_r : '0);
  assign imm_ext   = {{(DATA_W-IMM_BITS){s1_item_r.immediate[IMM_BITS-1]}},
                      s1_item_r.immediate};
  assign right_op  = s1_item_r.use_immediate ? imm_ext : reg_right;

  afrf_alu u_alu (
    .op_code  (s1_item_r.operation),
    .left     (left_op),
    .right    (right_op),
    .flags_in (flags_r),
    .res      (alu_res)
  );

  // Status register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (s1_fire) begin
      flags_r <= alu_res.flags;
    end
  end

  // Output register
  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.result_value  <= alu_res.result;
      out_data_r.flag_zero     <= alu_res.flags[FLAG_Z];
      out_data_r.flag_negative <= alu_res.flags[FLAG_N];
      out_data_r.flag_overflow <= alu_res.flags[FLAG_V];
      out_data_r.flag_carry    <= alu_res.flags[FLAG_C];
      out_data_r.invalid_op    <= alu_res.invalid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/afrf_checker.sv
// Port-level checker for the ALU unit and its bind statement.
module afrf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input afrf_pkg::out_item_t out_data
);
  import afrf_pkg::*;

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Unknown operations report a zero value
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid_op |-> out_data.result_value == '0)
    else $error("invalid operation with nonzero result");

  // Backpressure only when the output is stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // An accepted transaction is followed by a valid result on the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing after accepted transaction");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind alu_with_flags_and_register_file_unit afrf_checker u_afrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
